### rtl/core/setcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setcs_pkg
// Shared sizes, types and helpers of the sorted event table search unit.
// ----------------------------------------------------------------------------
package setcs_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int KIND_BITS   = 4;

   localparam int TIME_W      = 28;
   localparam int KIND_PORT_W = 4;
   localparam int POS_W       = 12;
   localparam int OP_W        = 2;

   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_SKIP = 2'd1,
      OP_JUMP = 2'd2,
      OP_GET  = 2'd3
   } op_type;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [TIME_W-1:0]    stamp;
      logic [KIND_BITS-1:0] kind;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } before_type;

   typedef struct packed {
      logic       found;
      entry_type  entry;
      idx_type    pos;
      before_type prev;
   } res_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } mem_req_type;

   function automatic logic [KIND_PORT_W-1:0] kind_to_port(input logic [KIND_BITS-1:0] k);
      logic [7:0] w;
      w = 8'(k);
      return w[KIND_PORT_W-1:0];
   endfunction

   function automatic logic [KIND_BITS-1:0] kind_from_port(input logic [KIND_PORT_W-1:0] k);
      logic [7:0] w;
      w = 8'(k);
      return w[KIND_BITS-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pos_to_port(input idx_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[POS_W-1:0];
   endfunction

   function automatic idx_type idx_from_port(input logic [POS_W-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/sorted_event_table_cursor_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_event_table_cursor_search_unit
// Sorted event table with a cursor: append, lower-bound skip/jump, get.
//
//   channel   ports                         handshake
//   request   req_*                         start high while busy low
//   result    rsp_*                         rsp_valid, one cycle, no stall
//
// Load, misses found at accept and out-of-range gets: result in the cycle after
// accept. Get: the table read (S_GET), then the result register. Skip/jump:
// probes of the table read port (up to log2(entries from cursor) + 1 probes, 13
// for a full table), a read of the entry before the new cursor on a hit past the
// first entry (S_PREV), then the result register.
// Reset clears entry count and cursor; table contents are not cleared.
// Results cannot be stalled; busy is high while an item is in progress.
// ----------------------------------------------------------------------------
module sorted_event_table_cursor_search_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [setcs_pkg::OP_W-1:0]           req_operation,
   input  wire logic [setcs_pkg::TIME_W-1:0]         req_event_time,
   input  wire logic [setcs_pkg::KIND_PORT_W-1:0]    req_event_kind,
   input  wire logic [setcs_pkg::POS_W-1:0]          req_entry_index,
   output logic                                      rsp_valid,
   output logic                                      rsp_found,
   output logic [setcs_pkg::TIME_W-1:0]              rsp_hit_time,
   output logic [setcs_pkg::KIND_PORT_W-1:0]         rsp_hit_kind,
   output logic [setcs_pkg::POS_W-1:0]               rsp_hit_position,
   output logic                                      rsp_before_valid,
   output logic [setcs_pkg::TIME_W-1:0]              rsp_before_time,
   output logic [setcs_pkg::KIND_PORT_W-1:0]         rsp_before_kind
);
   import setcs_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rd;
   logic        done;
   res_type     result;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type res_ff, res_in;

   setcs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_operation   (req_operation),
      .req_event_time  (req_event_time),
      .req_event_kind  (req_event_kind),
      .req_entry_index (req_entry_index),
      .busy            (busy),
      .done            (done),
      .result          (result),
      .mem_req         (mem_req),
      .mem_rd          (mem_rd)
   );

   setcs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd)
   );

   assign rsp_valid_in = done;
   assign res_in       = done ? result : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = res_ff.found;
   assign rsp_hit_time     = res_ff.entry.stamp;
   assign rsp_hit_kind     = kind_to_port(res_ff.entry.kind);
   assign rsp_hit_position = pos_to_port(res_ff.pos);
   assign rsp_before_valid = res_ff.prev.valid;
   assign rsp_before_time  = res_ff.prev.entry.stamp;
   assign rsp_before_kind  = kind_to_port(res_ff.prev.entry.kind);

endmodule
`default_nettype wire

### rtl/core/setcs_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setcs_store
// Event table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module setcs_store (
   input  wire logic                  clock,
   input  setcs_pkg::mem_req_type     mem_req,
   output setcs_pkg::entry_type       rd_data
);
   import setcs_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/setcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setcs_ctrl
// Sequencer: append, lower-bound search one probe per cycle, indexed read,
// cursor and previous-entry tracking.
// ----------------------------------------------------------------------------
module setcs_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [setcs_pkg::OP_W-1:0]    req_operation,
   input  wire logic [setcs_pkg::TIME_W-1:0]  req_event_time,
   input  wire logic [setcs_pkg::KIND_PORT_W-1:0] req_event_kind,
   input  wire logic [setcs_pkg::POS_W-1:0]   req_entry_index,
   output logic                               busy,
   output logic                               done,
   output setcs_pkg::res_type                 result,
   output setcs_pkg::mem_req_type             mem_req,
   input  setcs_pkg::entry_type               mem_rd
);
   import setcs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_PREV   = 4'b0100,
      S_GET    = 4'b1000
   } state_type;

   typedef struct packed {
      entry_type entry;
      idx_type   pos;
   } hit_type;

   function automatic idx_type mid_of(input cnt_type lo, input cnt_type hi);
      logic [CNT_W:0] s;
      s = {1'b0, lo} + {1'b0, hi};
      return s[IDX_W:1];
   endfunction

   state_type         state_ff, state_in;
   cnt_type           count_ff, count_in;
   idx_type           cursor_ff, cursor_in;
   logic [TIME_W-1:0] last_ff, last_in;
   cnt_type           lo_ff, lo_in;
   cnt_type           hi_ff, hi_in;
   idx_type           mid_ff, mid_in;
   logic [TIME_W-1:0] key_ff, key_in;
   hit_type           hit_ff, hit_in;
   before_type        before_ff, before_in;

   op_type  op;
   cnt_type lo_start;
   cnt_type lo_n;
   cnt_type hi_n;
   logic    less;

   assign op       = op_type'(req_operation);
   assign lo_start = (op == OP_JUMP) ? '0 : CNT_W'(cursor_ff);
   assign less     = mem_rd.stamp < key_ff;
   assign lo_n     = less ? CNT_W'(mid_ff) + CNT_W'(1) : lo_ff;
   assign hi_n     = less ? hi_ff : CNT_W'(mid_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      last_in   = last_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      key_in    = key_ff;
      hit_in    = hit_ff;
      before_in = before_ff;
      mem_req   = '0;
      done      = 1'b0;
      result    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (op)
                  OP_LOAD: begin
                     done = 1'b1;
                     if (count_ff != CNT_W'(TABLE_DEPTH) &&
                         (count_ff == '0 || req_event_time > last_ff)) begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = count_ff[IDX_W-1:0];
                        mem_req.wr_data.stamp = req_event_time;
                        mem_req.wr_data.kind  = kind_from_port(req_event_kind);
                        count_in              = count_ff + CNT_W'(1);
                        last_in               = req_event_time;
                        result.found          = 1'b1;
                        result.pos            = count_ff[IDX_W-1:0];
                     end
                  end
                  OP_SKIP, OP_JUMP: begin
                     if (op == OP_JUMP) begin
                        cursor_in = '0;
                        before_in = '0;
                     end
                     key_in = req_event_time;
                     if (lo_start < count_ff) begin
                        lo_in           = lo_start;
                        hi_in           = count_ff;
                        mid_in          = mid_of(lo_start, count_ff);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = mid_of(lo_start, count_ff);
                        state_in        = S_SEARCH;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_GET: begin
                     if (32'(req_entry_index) < 32'(count_ff)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_from_port(req_entry_index);
                        hit_in.pos      = idx_from_port(req_entry_index);
                        state_in        = S_GET;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (!less) begin
               hit_in.entry = mem_rd;
               hit_in.pos   = mid_ff;
            end
            if (lo_n < hi_n) begin
               mid_in          = mid_of(lo_n, hi_n);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_of(lo_n, hi_n);
            end else if (lo_n < count_ff) begin
               if (lo_n != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = IDX_W'(lo_n - CNT_W'(1));
                  state_in        = S_PREV;
               end else begin
                  // hit at the first entry: nothing before it
                  cursor_in    = '0;
                  before_in    = '0;
                  done         = 1'b1;
                  result.found = 1'b1;
                  result.entry = hit_in.entry;
                  result.pos   = hit_in.pos;
                  state_in     = S_IDLE;
               end
            end else begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PREV: begin
            cursor_in       = hit_ff.pos;
            before_in.valid = 1'b1;
            before_in.entry = mem_rd;
            done            = 1'b1;
            result.found    = 1'b1;
            result.entry    = hit_ff.entry;
            result.pos      = hit_ff.pos;
            state_in        = S_IDLE;
         end
         S_GET: begin
            done         = 1'b1;
            result.found = 1'b1;
            result.entry = mem_rd;
            result.pos   = hit_ff.pos;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      result.prev = before_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         before_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         before_ff <= before_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      key_ff  <= key_in;
      hit_ff  <= hit_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == '0 || CNT_W'(cursor_ff) < count_ff)
      else $error("cursor points past loaded entries");

   a_before_tracks_cursor: assert property (@(posedge clock) disable iff (reset)
      before_ff.valid == (cursor_ff != '0))
      else $error("previous entry flag out of step with cursor");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> lo_ff < hi_ff && hi_ff <= count_ff)
      else $error("search window empty or beyond table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == S_IDLE)
      else $error("sequencer not idle after result");
`endif

endmodule
`default_nettype wire
